/* hw/rtl/rtt_pkg.sv */
// Shared constants, codes and control/status types of the request timeout table.
`default_nettype none
package rtt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] CMD_REGISTER   = 3'd0;
  localparam logic [2:0] CMD_UNREGISTER = 3'd1;
  localparam logic [2:0] CMD_TOUCH      = 3'd2;
  localparam logic [2:0] CMD_QUERY      = 3'd3;
  localparam logic [2:0] CMD_TICK       = 3'd4;
  localparam logic [2:0] CMD_CLEAR      = 3'd5;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_ZERO_ID = 2'd1;
  localparam logic [1:0] ERR_FULL    = 2'd2;

  localparam logic [1:0] REG_CLASS0 = 2'd0;
  localparam logic [1:0] REG_CLASS1 = 2'd1;
  localparam logic [1:0] REG_CLASS2 = 2'd2;

  localparam logic [30:0] CLASS0_RESET     = 31'd30000;
  localparam logic [30:0] CLASS1_RESET     = 31'd120000;
  localparam logic [30:0] CLASS2_RESET     = 31'd180000;
  localparam logic [30:0] FALLBACK_TIMEOUT = 31'd30000;

  typedef enum logic [1:0] {
    MODE_FIND,
    MODE_COUNT,
    MODE_EMIT
  } mode_e;

  typedef struct packed {
    logic  latch;
    logic  scan_start;
    logic  scan_en;
    mode_e mode;
    logic  commit_load;
    logic  emit_load;
  } ctl_t;

  typedef struct packed {
    logic             eval_last;
    logic             hit;
    logic             out_busy;
    logic             nexp_zero;
    logic             emit_last;
    logic [CNT_W-1:0] entry_count;
  } sts_t;

  typedef struct packed {
    logic [31:0]      expiry_total;
    logic [CNT_W-1:0] entry_count;
    logic [1:0]       expired_class;
    logic [31:0]      expired_id;
    logic             expired_valid;
    logic [32:0]      remaining_ms;
    logic [31:0]      elapsed_ms;
    logic [1:0]       found_class;
    logic [1:0]       error;
    logic             ok;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage
`default_nettype wire

/* hw/rtl/request_timeout_table.sv */
// Request timeout table: top level joining the controller and the datapath.
// Register of a nonzero ID, unregister, touch and query scan all slots.
// Tick scans the slots to count the expired entries, then again to emit them if any expired.
// Clear, ID-zero register and unused codes skip the scan. One command is worked on at a time;
// the scan reads one slot per cycle from slot memory unless an output stall holds the emit scan.
// Reset clears all slot valid bits, the clock and the expiry count at once; no clearing pass.
`default_nettype none
module request_timeout_table import rtt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // tdata fields from bit 0: request_id[31:0], request_class[33:32], tick_ms[49:34].
  input  wire logic [55:0]      s_tdata,
  // tuser fields from bit 0: cmd[2:0].
  input  wire logic [2:0]       s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // tdata fields from bit 0: ok, error, found_class, elapsed_ms, remaining_ms,
  // expired_valid, expired_id, expired_class, entry_count, expiry_total.
  output logic      [RES_W-1:0] m_tdata,
  output logic                  m_tlast
);

  ctl_t ctl;
  sts_t sts;

  assign pready = 1'b1;

  rtt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .in_cmd_i     (s_tuser),
    .in_id_zero_i (s_tdata[31:0] == 32'd0),
    .sts_i        (sts),
    .s_tready_o   (s_tready),
    .ctl_o        (ctl)
  );

  rtt_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_o   (prdata),
    .in_cmd_i   (s_tuser),
    .in_id_i    (s_tdata[31:0]),
    .in_class_i (s_tdata[33:32]),
    .in_tick_i  (s_tdata[49:34]),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tlast_o  (m_tlast)
  );

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.emit_load || ctl.commit_load) |-> !sts.out_busy)
    else $error("result loaded while the output register is stalled");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.emit_load || ctl.commit_load) |=> m_tvalid)
    else $error("loaded result not presented");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.scan_en |-> !s_tready)
    else $error("input accepted during a scan");

endmodule
`default_nettype wire

/* hw/rtl/rtt_ctrl.sv */
// Controller state machine that sequences the table scans for each command.
`default_nettype none
module rtt_ctrl import rtt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_tvalid_i,
  input  wire logic [2:0] in_cmd_i,
  input  wire logic       in_id_zero_i,
  input  wire sts_t       sts_i,
  output logic            s_tready_o,
  output ctl_t            ctl_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_COUNT,
    ST_EMIT_START,
    ST_EMIT,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   needs_find;

  assign accept = s_tvalid_i && (state_q == ST_IDLE);
  assign needs_find = ((in_cmd_i == CMD_REGISTER) && !in_id_zero_i) ||
                      (in_cmd_i == CMD_UNREGISTER) || (in_cmd_i == CMD_TOUCH) ||
                      (in_cmd_i == CMD_QUERY);

  always_comb begin
    state_d           = state_q;
    s_tready_o        = 1'b0;
    ctl_o             = '0;
    ctl_o.mode        = MODE_FIND;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (accept) begin
          ctl_o.latch = 1'b1;
          if (needs_find) begin
            ctl_o.scan_start = 1'b1;
            state_d          = ST_FIND;
          end else if (in_cmd_i == CMD_TICK) begin
            ctl_o.scan_start = 1'b1;
            state_d          = ST_COUNT;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_FIND: begin
        ctl_o.scan_en = 1'b1;
        if (sts_i.eval_last) state_d = ST_RESULT;
      end
      ST_COUNT: begin
        ctl_o.mode    = MODE_COUNT;
        ctl_o.scan_en = 1'b1;
        if (sts_i.eval_last) state_d = ST_EMIT_START;
      end
      ST_EMIT_START: begin
        ctl_o.mode = MODE_EMIT;
        if (sts_i.nexp_zero) begin
          state_d = ST_RESULT;
        end else begin
          ctl_o.scan_start = 1'b1;
          state_d          = ST_EMIT;
        end
      end
      ST_EMIT: begin
        ctl_o.mode      = MODE_EMIT;
        ctl_o.scan_en   = !(sts_i.hit && sts_i.out_busy);
        ctl_o.emit_load = sts_i.hit && !sts_i.out_busy;
        if (ctl_o.emit_load && sts_i.emit_last) state_d = ST_IDLE;
      end
      ST_RESULT: begin
        ctl_o.commit_load = !sts_i.out_busy;
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rtt_datapath.sv */
// Datapath: configuration registers, slot memory, scan pipeline, counters and result register.
`default_nettype none
module rtt_datapath import rtt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel_i,
  input  wire logic             penable_i,
  input  wire logic             pwrite_i,
  input  wire logic [3:0]       paddr_i,
  input  wire logic [31:0]      pwdata_i,
  output logic      [31:0]      prdata_o,
  input  wire logic [2:0]       in_cmd_i,
  input  wire logic [31:0]      in_id_i,
  input  wire logic [1:0]       in_class_i,
  input  wire logic [15:0]      in_tick_i,
  input  wire ctl_t             ctl_i,
  output sts_t                  sts_o,
  output logic                  m_tvalid_o,
  input  wire logic             m_tready_i,
  output logic      [RES_W-1:0] m_tdata_o,
  output logic                  m_tlast_o
);

  localparam int WORD_W = 66;

  logic [30:0] tmo0_q, tmo1_q, tmo2_q;
  logic [2:0]  cmd_q;
  logic [31:0] id_q;
  logic [1:0]  cls_q;
  logic [31:0] clock_q;
  logic [31:0] expiry_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] nexp_q, emitted_q;

  logic [WORD_W-1:0] mem [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_word_q;
  logic [TABLE_DEPTH-1:0] vld_q;
  logic [IDX_W-1:0] addr_q, rd_idx_q;
  logic issue_q, rd_act_q, rd_vld_q;

  logic found_q, free_q;
  logic [IDX_W-1:0] found_idx_q, free_idx_q;
  logic [1:0]  cap_cls_q;
  logic [31:0] cap_elapsed_q;
  logic [30:0] cap_tmo_q;

  res_t res_q, res_d;
  logic m_tvalid_q, m_tlast_q;

  logic        cfg_we;
  logic [31:0] rd_id, rd_start, ev_elapsed;
  logic [1:0]  rd_cls;
  logic [30:0] ev_tmo;
  logic [32:0] ev_remaining;
  logic        ev_hit, ev_match, ev_free;
  logic        find_step, count_hit;
  logic        is_reg, id_nz, reg_write, count_inc, unreg_clear;
  logic [IDX_W-1:0] waddr;

  function automatic logic [30:0] timeout_of(logic [1:0] cls, logic [30:0] t0,
                                              logic [30:0] t1, logic [30:0] t2);
    logic [30:0] t;
    unique case (cls)
      2'd0:    t = t0;
      2'd1:    t = t1;
      2'd2:    t = t2;
      default: t = FALLBACK_TIMEOUT;
    endcase
    return t;
  endfunction

  // Configuration port. A write whose low 31 bits are zero leaves the register unchanged.
  assign cfg_we = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo0_q <= CLASS0_RESET;
      tmo1_q <= CLASS1_RESET;
      tmo2_q <= CLASS2_RESET;
    end else if (cfg_we && (pwdata_i[30:0] != 31'd0)) begin
      unique case (paddr_i[3:2])
        REG_CLASS0: tmo0_q <= pwdata_i[30:0];
        REG_CLASS1: tmo1_q <= pwdata_i[30:0];
        REG_CLASS2: tmo2_q <= pwdata_i[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[3:2])
      REG_CLASS0: prdata_o = {1'b0, tmo0_q};
      REG_CLASS1: prdata_o = {1'b0, tmo1_q};
      REG_CLASS2: prdata_o = {1'b0, tmo2_q};
      default:    prdata_o = 32'd0;
    endcase
  end

  // Evaluation of the slot at the read stage of the scan.
  assign rd_id        = rd_word_q[31:0];
  assign rd_cls       = rd_word_q[33:32];
  assign rd_start     = rd_word_q[65:34];
  assign ev_elapsed   = clock_q - rd_start;
  assign ev_tmo       = timeout_of(rd_cls, tmo0_q, tmo1_q, tmo2_q);
  assign ev_remaining = {2'b00, ev_tmo} - {1'b0, ev_elapsed};
  assign ev_hit       = rd_act_q && rd_vld_q && (ev_elapsed >= {1'b0, ev_tmo});
  assign ev_match     = rd_act_q && rd_vld_q && (rd_id == id_q);
  assign ev_free      = rd_act_q && !rd_vld_q;

  assign find_step = ctl_i.scan_en && (ctl_i.mode == MODE_FIND);
  assign count_hit = ctl_i.scan_en && (ctl_i.mode == MODE_COUNT) && ev_hit;

  assign is_reg      = (cmd_q == CMD_REGISTER);
  assign id_nz       = (id_q != 32'd0);
  assign reg_write   = ctl_i.commit_load && is_reg && id_nz && (found_q || free_q);
  assign waddr       = found_q ? found_idx_q : free_idx_q;
  assign count_inc   = reg_write && !found_q;
  assign unreg_clear = ctl_i.commit_load && (cmd_q == CMD_UNREGISTER) && found_q;

  always_comb begin
    count_d = count_q;
    if (count_hit || unreg_clear) begin
      count_d = count_q - CNT_W'(1);
    end else if (count_inc) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  // Slot memory and its registered scan read.
  always_ff @(posedge clk_i) begin
    if (reg_write) mem[waddr] <= {clock_q, cls_q, id_q};
    if (ctl_i.scan_en && issue_q) rd_word_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      addr_q   <= '0;
      rd_idx_q <= '0;
      issue_q  <= 1'b0;
      rd_act_q <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      if (reg_write) vld_q[waddr] <= 1'b1;
      if (unreg_clear) vld_q[found_idx_q] <= 1'b0;
      if (ctl_i.emit_load) vld_q[rd_idx_q] <= 1'b0;
      if (ctl_i.scan_start) begin
        addr_q   <= '0;
        issue_q  <= 1'b1;
        rd_act_q <= 1'b0;
      end else if (ctl_i.scan_en) begin
        rd_act_q <= issue_q;
        if (issue_q) begin
          rd_idx_q <= addr_q;
          rd_vld_q <= vld_q[addr_q];
          addr_q   <= addr_q + IDX_W'(1);
          if (addr_q == IDX_W'(TABLE_DEPTH - 1)) issue_q <= 1'b0;
        end
      end
    end
  end

  // Input capture, millisecond clock and counters.
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q <= in_cmd_i;
      id_q  <= in_id_i;
      cls_q <= in_class_i;
    end
    if (find_step && ev_match && !found_q) begin
      found_idx_q   <= rd_idx_q;
      cap_cls_q     <= rd_cls;
      cap_elapsed_q <= ev_elapsed;
      cap_tmo_q     <= ev_tmo;
    end
    if (find_step && ev_free && !free_q) free_idx_q <= rd_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q   <= '0;
      expiry_q  <= '0;
      count_q   <= '0;
      nexp_q    <= '0;
      emitted_q <= '0;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (ctl_i.latch) begin
        found_q   <= 1'b0;
        free_q    <= 1'b0;
        nexp_q    <= '0;
        emitted_q <= '0;
        if (in_cmd_i == CMD_TICK) clock_q <= clock_q + {16'd0, in_tick_i};
        if (in_cmd_i == CMD_CLEAR) expiry_q <= '0;
      end
      if (find_step && ev_match) found_q <= 1'b1;
      if (find_step && ev_free) free_q <= 1'b1;
      if (count_hit) begin
        nexp_q <= nexp_q + CNT_W'(1);
        if (expiry_q != '1) expiry_q <= expiry_q + 32'd1;
      end
      if (ctl_i.emit_load) emitted_q <= emitted_q + CNT_W'(1);
    end
  end

  // Result assembly and output register.
  always_comb begin
    res_d              = '0;
    res_d.entry_count  = count_d;
    res_d.expiry_total = expiry_q;
    if (ctl_i.emit_load) begin
      res_d.elapsed_ms    = ev_elapsed;
      res_d.remaining_ms  = ev_remaining;
      res_d.expired_valid = 1'b1;
      res_d.expired_id    = rd_id;
      res_d.expired_class = rd_cls;
    end else begin
      if (is_reg) begin
        if (!id_nz) begin
          res_d.error = ERR_ZERO_ID;
        end else if (found_q || free_q) begin
          res_d.ok = 1'b1;
        end else begin
          res_d.error = ERR_FULL;
        end
      end else if ((cmd_q == CMD_UNREGISTER) || (cmd_q == CMD_TOUCH)) begin
        res_d.ok = found_q;
      end else if ((cmd_q == CMD_QUERY) && found_q) begin
        res_d.ok           = 1'b1;
        res_d.found_class  = cap_cls_q;
        res_d.elapsed_ms   = cap_elapsed_q;
        res_d.remaining_ms = {2'b00, cap_tmo_q} - {1'b0, cap_elapsed_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_load || ctl_i.commit_load) begin
      res_q     <= res_d;
      m_tlast_q <= ctl_i.commit_load || (emitted_q + CNT_W'(1) == nexp_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (ctl_i.emit_load || ctl_i.commit_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = res_q;
  assign m_tlast_o  = m_tlast_q;

  assign sts_o.eval_last   = rd_act_q && (rd_idx_q == IDX_W'(TABLE_DEPTH - 1));
  assign sts_o.hit         = ev_hit;
  assign sts_o.out_busy    = m_tvalid_q && !m_tready_i;
  assign sts_o.nexp_zero   = (nexp_q == '0);
  assign sts_o.emit_last   = (emitted_q + CNT_W'(1) == nexp_q);
  assign sts_o.entry_count = count_q;

endmodule
`default_nettype wire

/* bench/tb.sv */
// Testbench for the request timeout table: random and directed commands checked against a predictor.
`default_nettype none
module tb;
  import rtt_pkg::*;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] id;
    logic [1:0]  cls;
    logic [15:0] tick;
  } cmd_item_t;

  class timeout_scoreboard;
    bit          valid_q[TABLE_DEPTH];
    logic [31:0] id_q[TABLE_DEPTH];
    logic [1:0]  cls_q[TABLE_DEPTH];
    logic [31:0] start_q[TABLE_DEPTH];
    logic [31:0] clock_ms;
    logic [31:0] expiries;
    logic [30:0] limit_ms[3];
    res_t        pending[$];
    bit          last_pending[$];
    int          mismatches;

    function void reset_state();
      foreach (valid_q[i]) valid_q[i] = 0;
      clock_ms = 0;
      expiries = 0;
      limit_ms[0] = CLASS0_RESET;
      limit_ms[1] = CLASS1_RESET;
      limit_ms[2] = CLASS2_RESET;
    endfunction

    function void write_limit(logic [1:0] idx, logic [31:0] value);
      if (value[30:0] != 0) limit_ms[idx] = value[30:0];
    endfunction

    function logic [31:0] limit_of(logic [1:0] c);
      return (c == 2'd3) ? {1'b0, FALLBACK_TIMEOUT} : {1'b0, limit_ms[c]};
    endfunction

    function int lookup(logic [31:0] id);
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (valid_q[i] && id_q[i] == id) return i;
      return -1;
    endfunction

    function logic [CNT_W-1:0] occupancy();
      int n;
      n = 0;
      foreach (valid_q[i]) n += valid_q[i];
      return CNT_W'(n);
    endfunction

    function void note_command(cmd_item_t it);
      res_t r;
      res_t batch[$];
      int s;
      logic [31:0] e;
      logic [31:0] t;
      r = '0;
      case (it.cmd)
        CMD_REGISTER: begin
          if (it.id == 0) r.error = ERR_ZERO_ID;
          else begin
            s = lookup(it.id);
            if (s < 0)
              for (int i = 0; i < TABLE_DEPTH; i++)
                if (!valid_q[i]) begin s = i; break; end
            if (s < 0) r.error = ERR_FULL;
            else begin
              valid_q[s] = 1; id_q[s] = it.id; cls_q[s] = it.cls;
              start_q[s] = clock_ms; r.ok = 1;
            end
          end
        end
        CMD_UNREGISTER: begin
          s = lookup(it.id);
          if (s >= 0) begin valid_q[s] = 0; r.ok = 1; end
        end
        CMD_TOUCH: r.ok = lookup(it.id) >= 0;
        CMD_QUERY: begin
          s = lookup(it.id);
          if (s >= 0) begin
            e = clock_ms - start_q[s];
            r.ok = 1; r.found_class = cls_q[s]; r.elapsed_ms = e;
            r.remaining_ms = {1'b0, limit_of(cls_q[s])} - {1'b0, e};
          end
        end
        CMD_TICK: begin
          clock_ms += it.tick;
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!valid_q[i]) continue;
            e = clock_ms - start_q[i];
            t = limit_of(cls_q[i]);
            if (e < t) continue;
            valid_q[i] = 0;
            if (expiries != 32'hFFFF_FFFF) expiries++;
            r = '0;
            r.elapsed_ms = e;
            r.remaining_ms = {1'b0, t} - {1'b0, e};
            r.expired_valid = 1; r.expired_id = id_q[i]; r.expired_class = cls_q[i];
            batch = {batch, r};
          end
          r = '0;
        end
        CMD_CLEAR: expiries = 0;
        default: ;
      endcase
      if (batch.size() == 0) batch = {batch, r};
      foreach (batch[k]) begin
        batch[k].entry_count = occupancy();
        batch[k].expiry_total = expiries;
        pending = {pending, batch[k]};
        last_pending = {last_pending, bit'(k == batch.size() - 1)};
      end
    endfunction

    function void check_result(res_t got, logic got_last);
      res_t x;
      bit xl;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      x = pending.pop_front();
      xl = last_pending.pop_front();
      if (got !== x || got_last !== xl) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h last %0b, got %h last %0b", x, xl, got, got_last);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 0;
  logic s_tready;
  logic [55:0] s_tdata = 0;
  logic [2:0] s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [RES_W-1:0] m_tdata;
  logic m_tlast;

  request_timeout_table dut (.*);

  always #5 clk_i = ~clk_i;

  timeout_scoreboard table_model = new();
  int send_idle_pct = 29;
  int recv_idle_pct = 66;
  bit recv_hold = 0;
  int quiet_cycles = 0;
  logic [31:0] known_ids[$];

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) table_model.check_result(m_tdata, m_tlast);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb: FAIL");
      $finish;
    end
    m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_limit_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    table_model.write_limit(idx, value);
    @(posedge clk_i);
  endtask

  task automatic send_command(cmd_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk_i);
    end
    s_tvalid <= 1;
    s_tuser <= it.cmd;
    s_tdata <= {6'd0, it.tick, it.cls, it.id};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    table_model.note_command(it);
  endtask

  task automatic send(logic [2:0] c, logic [31:0] id, logic [1:0] cls, logic [15:0] t);
    cmd_item_t it;
    it.cmd = c; it.id = id; it.cls = cls; it.tick = t;
    send_command(it);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (table_model.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_command();
    cmd_item_t it;
    int pick;
    pick = $urandom_range(99);
    it.cls = 2'($urandom_range(3));
    it.tick = 16'(($urandom_range(9) == 0) ? $urandom : $urandom_range(200));
    if (known_ids.size() != 0 && $urandom_range(2) != 0)
      it.id = known_ids[$urandom_range(known_ids.size() - 1)];
    else begin
      it.id = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
      if (known_ids.size() < 80) known_ids = {known_ids, it.id};
    end
    if (pick < 40) it.cmd = CMD_REGISTER;
    else if (pick < 50) it.cmd = CMD_UNREGISTER;
    else if (pick < 58) it.cmd = CMD_TOUCH;
    else if (pick < 70) it.cmd = CMD_QUERY;
    else if (pick < 95) it.cmd = CMD_TICK;
    else if (pick < 98) it.cmd = CMD_CLEAR;
    else it.cmd = 3'($urandom_range(7, 6));
    send_command(it);
  endtask

  initial begin
    table_model.reset_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    write_limit_reg(REG_CLASS0, 32'd50);
    write_limit_reg(REG_CLASS1, 32'd300);
    write_limit_reg(REG_CLASS2, 32'h8000_0000);
    send(CMD_REGISTER, 32'd0, 2'd0, 16'd0);
    send(CMD_REGISTER, 32'hFFFF_FFFF, 2'd0, 16'd0);
    send(CMD_REGISTER, 32'd1, 2'd1, 16'd0);
    send(CMD_REGISTER, 32'd2, 2'd2, 16'd0);
    send(CMD_REGISTER, 32'd3, 2'd3, 16'd0);
    send(CMD_REGISTER, 32'd1, 2'd0, 16'd0);
    send(CMD_TOUCH, 32'd2, 2'd0, 16'd0);
    send(CMD_TOUCH, 32'd0, 2'd0, 16'd0);
    send(CMD_QUERY, 32'd3, 2'd0, 16'd0);
    send(CMD_UNREGISTER, 32'd2, 2'd0, 16'd0);
    send(CMD_UNREGISTER, 32'd2, 2'd0, 16'd0);
    send(CMD_TICK, 32'd0, 2'd0, 16'd10);
    send(CMD_TICK, 32'd0, 2'd0, 16'hFFFF);
    send(CMD_QUERY, 32'hFFFF_FFFF, 2'd0, 16'd0);
    send(CMD_CLEAR, 32'd0, 2'd0, 16'd0);
    send(3'd6, 32'hAAAA_5555, 2'd3, 16'hFFFF);
    send(3'd7, 32'd0, 2'd0, 16'd0);
    for (int i = 0; i < 65; i++) send(CMD_REGISTER, 32'h100 + i, 2'(i % 3), 16'd0);
    send(CMD_TICK, 32'd0, 2'd0, 16'd100);
    drain();
    write_limit_reg(REG_CLASS0, 32'd0);
    write_limit_reg(REG_CLASS1, 32'd1);
    write_limit_reg(REG_CLASS2, 32'h7FFF_FFFF);
    for (int i = 0; i < 500; i++) begin
      if (i == 170) begin
        drain();
        send_idle_pct = 66; recv_idle_pct = 29;
        write_limit_reg(REG_CLASS0, 32'd400);
        write_limit_reg(REG_CLASS1, 32'd120);
        write_limit_reg(REG_CLASS2, 32'd900);
      end
      if (i == 340) begin
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        recv_hold = 1;
      end
      random_command();
    end
    drain();
    if (table_model.mismatches == 0 && table_model.pending.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  initial begin
    wait (recv_hold);
    repeat (600) @(posedge clk_i);
    recv_hold = 0;
  end
endmodule
`default_nettype wire

/* files.f */
hw/rtl/rtt_pkg.sv
hw/rtl/rtt_ctrl.sv
hw/rtl/rtt_datapath.sv
hw/rtl/request_timeout_table.sv
bench/tb.sv
